FILE: hw/rtl/mqd_pkg.sv
// types and codes shared by the mqtt receive deframer
// no dependencies

package mqd_pkg;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_LEN,
      PH_BODY
   } phase_type;

   typedef enum logic [0:0] {
      REQ_BYTE      = 1'b0,
      REQ_LINK_DOWN = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_TOPIC   = 2'd1,
      KIND_PAYLOAD = 2'd2,
      KIND_OTHER   = 2'd3
   } byte_kind_type;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_CONNECT_OK  = 3'd1,
      EV_CONNECT_REF = 3'd2,
      EV_SUBACK      = 3'd3,
      EV_PUB_DONE    = 3'd4,
      EV_PUB_DROP    = 3'd5,
      EV_BAD_LEN     = 3'd6
   } event_type;

   localparam logic [3:0] PKT_CONNACK = 4'd2;
   localparam logic [3:0] PKT_PUBLISH = 4'd3;
   localparam logic [3:0] PKT_SUBACK  = 4'd9;

   localparam logic [1:0] LEN_LAST_BYTE = 2'd3;
   localparam logic [1:0] POS_MAX       = 2'd3;
   localparam logic [1:0] ID_BYTES      = 2'd2;

   typedef struct packed {
      req_kind_type req_type;
      logic [7:0]   rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]    data_byte;
      byte_kind_type byte_kind;
      logic [3:0]    packet_type;
      logic [1:0]    qos_level;
      logic [15:0]   topic_length;
      event_type     event_res;
      logic          packet_last;
      logic          connected;
   } rsp_payload_type;

endpackage

FILE: hw/rtl/mqd_stream_if.sv
// valid/ready channels of the mqtt receive deframer
// no dependencies

interface mqd_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] rx_byte;

   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface mqd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [1:0]  byte_kind;
   logic [3:0]  packet_type;
   logic [1:0]  qos_level;
   logic [15:0] topic_length;
   logic [2:0]  event_res;
   logic        packet_last;
   logic        connected;

   modport source (
      output valid, output data_byte, output byte_kind, output packet_type,
      output qos_level, output topic_length, output event_res,
      output packet_last, output connected, input ready
   );
   modport sink (
      input valid, input data_byte, input byte_kind, input packet_type,
      input qos_level, input topic_length, input event_res,
      input packet_last, input connected, output ready
   );
endinterface

FILE: hw/rtl/mqd_stage_reg.sv
// one valid/ready register stage, used for the input and the result registers
// no dependencies

module mqd_stage_reg #(
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [Width-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [Width-1:0] out_data
);

   logic             valid_ff;
   logic             valid_in;
   logic [Width-1:0] data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

FILE: hw/rtl/mqd_parser.sv
// framing state and byte classification of the mqtt receive deframer
// depends on mqd_pkg

module mqd_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  mqd_pkg::req_payload_type req,
   output mqd_pkg::rsp_payload_type rsp
);

   mqd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  type_ff, type_in;
   logic [1:0]  qos_ff, qos_in;
   logic [27:0] accum_ff, accum_in;
   logic [1:0]  count_ff, count_in;
   logic [27:0] body_left_ff, body_left_in;
   logic [1:0]  pos_ff, pos_in;
   logic [15:0] topic_len_ff, topic_len_in;
   logic [15:0] topic_left_ff, topic_left_in;
   logic [1:0]  id_left_ff, id_left_in;
   logic        pub_valid_ff, pub_valid_in;
   logic        ack_ok_ff, ack_ok_in;
   logic        session_ff, session_in;

   logic [7:0]  b;
   logic [27:0] group;
   logic [1:0]  id_need;
   logic        finish;
   mqd_pkg::event_type     ev;
   mqd_pkg::byte_kind_type kind;
   logic        last;
   logic [7:0]  data;

   assign b = req.rx_byte;

   always_comb begin
      case (count_ff)
         2'd0:    group = {21'd0, b[6:0]};
         2'd1:    group = {14'd0, b[6:0], 7'd0};
         2'd2:    group = {7'd0, b[6:0], 14'd0};
         default: group = {b[6:0], 21'd0};
      endcase
   end

   assign id_need = (qos_in != 2'd0) ? mqd_pkg::ID_BYTES : 2'd0;

   // next state
   always_comb begin
      phase_in      = phase_ff;
      type_in       = type_ff;
      qos_in        = qos_ff;
      accum_in      = accum_ff;
      count_in      = count_ff;
      body_left_in  = body_left_ff;
      pos_in        = pos_ff;
      topic_len_in  = topic_len_ff;
      topic_left_in = topic_left_ff;
      id_left_in    = id_left_ff;
      pub_valid_in  = pub_valid_ff;
      ack_ok_in     = ack_ok_ff;
      finish        = 1'b0;
      if (req.req_type == mqd_pkg::REQ_BYTE) begin
         unique case (phase_ff)
            mqd_pkg::PH_FIRST: begin
               type_in       = b[7:4];
               qos_in        = b[2:1];
               accum_in      = '0;
               count_in      = '0;
               topic_len_in  = '0;
               topic_left_in = '0;
               id_left_in    = '0;
               pub_valid_in  = 1'b0;
               ack_ok_in     = 1'b0;
               pos_in        = '0;
               phase_in      = mqd_pkg::PH_LEN;
            end
            mqd_pkg::PH_LEN: begin
               accum_in = accum_ff | group;
               if (b[7]) begin
                  if (count_ff == mqd_pkg::LEN_LAST_BYTE) begin
                     phase_in = mqd_pkg::PH_FIRST;
                  end else begin
                     count_in = count_ff + 2'd1;
                  end
               end else begin
                  body_left_in = accum_in;
                  pos_in       = '0;
                  if (accum_in == 28'd0) begin
                     finish   = 1'b1;
                     phase_in = mqd_pkg::PH_FIRST;
                  end else begin
                     phase_in = mqd_pkg::PH_BODY;
                  end
               end
            end
            default: begin
               body_left_in = body_left_ff - 28'd1;
               if (type_ff == mqd_pkg::PKT_PUBLISH) begin
                  if (pos_ff == 2'd0) begin
                     topic_len_in = {b, 8'd0};
                  end else if (pos_ff == 2'd1) begin
                     topic_len_in  = topic_len_ff | {8'd0, b};
                     topic_left_in = topic_len_in;
                     id_left_in    = id_need;
                     // topic + id must fit in what is left after this byte
                     pub_valid_in  = (28'(topic_len_in) + 28'(id_need)) < body_left_ff;
                  end else if (pub_valid_ff) begin
                     if (topic_left_ff != 16'd0) begin
                        topic_left_in = topic_left_ff - 16'd1;
                     end else if (id_left_ff != 2'd0) begin
                        id_left_in = id_left_ff - 2'd1;
                     end
                  end
               end else if (type_ff == mqd_pkg::PKT_CONNACK && pos_ff == 2'd1) begin
                  ack_ok_in = (b == 8'd0);
               end
               if (pos_ff != mqd_pkg::POS_MAX) begin
                  pos_in = pos_ff + 2'd1;
               end
               if (body_left_ff == 28'd1) begin
                  finish   = 1'b1;
                  phase_in = mqd_pkg::PH_FIRST;
               end
            end
         endcase
      end
   end

   // result fields
   always_comb begin
      kind       = mqd_pkg::KIND_HEADER;
      ev         = mqd_pkg::EV_NONE;
      last       = 1'b0;
      data       = b;
      session_in = session_ff;
      if (req.req_type == mqd_pkg::REQ_LINK_DOWN) begin
         session_in = 1'b0;
         data       = 8'd0;
      end else begin
         if (phase_ff == mqd_pkg::PH_LEN && b[7] && count_ff == mqd_pkg::LEN_LAST_BYTE) begin
            ev   = mqd_pkg::EV_BAD_LEN;
            last = 1'b1;
         end
         if (phase_ff == mqd_pkg::PH_BODY) begin
            if (type_ff != mqd_pkg::PKT_PUBLISH) begin
               kind = mqd_pkg::KIND_OTHER;
            end else if (pos_ff >= 2'd2 && pub_valid_ff) begin
               if (topic_left_ff != 16'd0) begin
                  kind = mqd_pkg::KIND_TOPIC;
               end else if (id_left_ff == 2'd0) begin
                  kind = mqd_pkg::KIND_PAYLOAD;
               end
            end
         end
         if (finish) begin
            last = 1'b1;
            if (type_in == mqd_pkg::PKT_CONNACK) begin
               if (pos_in >= 2'd2 && ack_ok_in) begin
                  ev         = mqd_pkg::EV_CONNECT_OK;
                  session_in = 1'b1;
               end else begin
                  ev = mqd_pkg::EV_CONNECT_REF;
               end
            end else if (type_in == mqd_pkg::PKT_PUBLISH) begin
               ev = pub_valid_in ? mqd_pkg::EV_PUB_DONE : mqd_pkg::EV_PUB_DROP;
            end else if (type_in == mqd_pkg::PKT_SUBACK) begin
               ev = mqd_pkg::EV_SUBACK;
            end
         end
      end
   end

   assign rsp.data_byte    = data;
   assign rsp.byte_kind    = kind;
   assign rsp.packet_type  = type_in;
   assign rsp.qos_level    = qos_in;
   assign rsp.topic_length = topic_len_in;
   assign rsp.event_res    = ev;
   assign rsp.packet_last  = last;
   assign rsp.connected    = session_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= mqd_pkg::PH_FIRST;
         type_ff       <= '0;
         qos_ff        <= '0;
         accum_ff      <= '0;
         count_ff      <= '0;
         body_left_ff  <= '0;
         pos_ff        <= '0;
         topic_len_ff  <= '0;
         topic_left_ff <= '0;
         id_left_ff    <= '0;
         pub_valid_ff  <= 1'b0;
         ack_ok_ff     <= 1'b0;
         session_ff    <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         type_ff       <= type_in;
         qos_ff        <= qos_in;
         accum_ff      <= accum_in;
         count_ff      <= count_in;
         body_left_ff  <= body_left_in;
         pos_ff        <= pos_in;
         topic_len_ff  <= topic_len_in;
         topic_left_ff <= topic_left_in;
         id_left_ff    <= id_left_in;
         pub_valid_ff  <= pub_valid_in;
         ack_ok_ff     <= ack_ok_in;
         session_ff    <= session_in;
      end
   end

   a_event_ends_packet: assert property (@(posedge clock) disable iff (reset)
      step && rsp.event_res != mqd_pkg::EV_NONE |-> rsp.packet_last)
      else $error("event reported without end of packet");

   a_last_resyncs: assert property (@(posedge clock) disable iff (reset)
      step && rsp.packet_last |=> phase_ff == mqd_pkg::PH_FIRST)
      else $error("parser not back at first byte after end of packet");

   a_body_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == mqd_pkg::PH_BODY |-> body_left_ff != 28'd0)
      else $error("body phase with no bytes left");

   a_link_down_clears: assert property (@(posedge clock) disable iff (reset)
      step && req.req_type == mqd_pkg::REQ_LINK_DOWN
      |-> !rsp.connected && !rsp.packet_last ##1 (!session_ff && $stable(phase_ff)))
      else $error("link down did not clear connected or moved the parser");

endmodule

FILE: hw/rtl/mqtt_packet_deframer.sv
// Receive deframer for MQTT 3.1.1: takes one byte (or a link-down marker) per
// transfer and returns one classified result per transfer. The block sustains
// one transfer per clock while the result side is ready; a request is held in
// the input register, the framing logic between the two registers computes its
// result, and that result is registered in the output register before it is
// presented. Both sides are registered, so a stalled result side holds at most
// two items before request ready drops.
// depends on mqd_pkg, mqd_stream_if, mqd_stage_reg, mqd_parser

module mqtt_packet_deframer (
   input logic       clock,
   input logic       reset,
   mqd_req_if.sink   req_chan,
   mqd_rsp_if.source rsp_chan
);

   localparam int ReqWidth = $bits(mqd_pkg::req_payload_type);
   localparam int RspWidth = $bits(mqd_pkg::rsp_payload_type);

   logic [ReqWidth-1:0] req_data;
   logic [ReqWidth-1:0] held_data;
   logic                held_valid;
   logic                rsp_in_ready;
   logic                step;
   logic [RspWidth-1:0] rsp_out_data;

   mqd_pkg::req_payload_type held_req;
   mqd_pkg::rsp_payload_type parse_rsp;
   mqd_pkg::rsp_payload_type rsp_out;

   assign req_data = {req_chan.req_type, req_chan.rx_byte};

   mqd_stage_reg #(.Width(ReqWidth)) u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_data),
      .out_valid (held_valid),
      .out_ready (rsp_in_ready),
      .out_data  (held_data)
   );

   assign held_req = mqd_pkg::req_payload_type'(held_data);
   assign step     = held_valid && rsp_in_ready;

   mqd_parser u_parser (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (held_req),
      .rsp   (parse_rsp)
   );

   mqd_stage_reg #(.Width(RspWidth)) u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (held_valid),
      .in_ready  (rsp_in_ready),
      .in_data   (parse_rsp),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_out_data)
   );

   assign rsp_out = mqd_pkg::rsp_payload_type'(rsp_out_data);

   assign rsp_chan.data_byte    = rsp_out.data_byte;
   assign rsp_chan.byte_kind    = rsp_out.byte_kind;
   assign rsp_chan.packet_type  = rsp_out.packet_type;
   assign rsp_chan.qos_level    = rsp_out.qos_level;
   assign rsp_chan.topic_length = rsp_out.topic_length;
   assign rsp_chan.event_res    = rsp_out.event_res;
   assign rsp_chan.packet_last  = rsp_out.packet_last;
   assign rsp_chan.connected    = rsp_out.connected;

endmodule
